// ----- hdl/scpb_pkg.sv -----
package scpb_pkg;

   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned PROD_W   = 2 * CHAN_W;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned NUM_CHAN = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_RED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_GREEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_BLUE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_LEVEL  = 3'd5;

   // blend modes
   localparam logic [1:0] MODE_MASK     = 2'd0;
   localparam logic [1:0] MODE_BLEND    = 2'd1;
   localparam logic [1:0] MODE_ADD      = 2'd2;
   localparam logic [1:0] MODE_MODULATE = 2'd3;

   // pixel formats; the unused code behaves as rgb888
   localparam logic [1:0] FMT_RGB555 = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;

   // channel slots
   localparam int unsigned CH_BLUE  = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_RED   = 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PROD_W-1:0] prod_type;

   // exact floor(x/255) for any 16-bit product of two bytes
   function automatic chan_type div255(input prod_type x);
      logic [PROD_W:0] t;
      logic [PROD_W:0] s;
      t = {1'b0, x} + 17'd1;
      s = t + (t >> 8);
      // s stays below 2^16 for products of two bytes
      return s[PROD_W-1:CHAN_W];
   endfunction

   // low bits dropped from an 8-bit color to fit the channel
   function automatic logic [1:0] chan_drop(input logic [1:0] fmt, input int unsigned ch);
      logic [1:0] d;
      d = 2'd0;
      case (fmt)
         FMT_RGB555: d = 2'd3;
         FMT_RGB565: d = (ch == CH_GREEN) ? 2'd2 : 2'd3;
         default:    d = 2'd0;
      endcase
      return d;
   endfunction

   // final per-channel combine; qa = color*alpha/255, qb = second product/255
   function automatic chan_type combine(input logic [1:0] mode, input logic pass,
                                        input logic [1:0] drop, input chan_type d,
                                        input chan_type qa, input chan_type qb,
                                        input chan_type c8);
      chan_type           maxv;
      chan_type           cs;
      logic [CHAN_W:0]    s;
      chan_type           r;
      maxv = CHAN_MAX >> drop;
      cs   = qa >> drop;
      s    = '0;
      r    = '0;
      case (mode)
         MODE_MASK: begin
            r = pass ? d : (c8 >> drop);
         end
         MODE_BLEND: begin
            s = {1'b0, qb} + {1'b0, cs};
            r = (s > {1'b0, maxv}) ? maxv : s[CHAN_W-1:0];
         end
         MODE_ADD: begin
            s = {1'b0, d} + {1'b0, cs};
            r = (s > {1'b0, maxv}) ? maxv : s[CHAN_W-1:0];
         end
         default: begin
            r = qb;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/solid_color_pixel_blend_core.sv -----
// Solid color pixel blender.
// req_* carries destination pixel words in, rsp_* carries result pixels out;
// a transfer happens on each edge where tvalid and tready are both high.
// The csr_* port writes the mode, format, color and alpha registers; write
// them only while no pixel is in flight.
// Pipeline: input register, multiply, divide-by-255, combine/pack register.
// rsp_tvalid rises once the pixel has passed through every stage register.
// Throughput is one pixel per cycle while rsp_tready stays high: every
// stage reloads on the same edge its content moves on.
// Each stage holds a valid bit; a stage loads whenever it is empty or its
// successor moves, so bubbles close up while the receiver stalls and up to
// four pixels queue inside before req_tready drops. Nothing is lost or
// repeated across a stall.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers: mask mode, rgb888, black color, alpha 255.
module solid_color_pixel_blend_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pixel_out
   // register writes
   input  logic        csr_wr_en,
   input  logic [scpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scpb_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   // ---------------- configuration registers ----------------
   logic [1:0]         blend_mode_ff;
   logic [1:0]         pixel_format_ff;
   scpb_pkg::chan_type color_ff [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff   <= scpb_pkg::MODE_MASK;
         pixel_format_ff <= scpb_pkg::FMT_RGB888;
         color_ff[scpb_pkg::CH_RED]   <= '0;
         color_ff[scpb_pkg::CH_GREEN] <= '0;
         color_ff[scpb_pkg::CH_BLUE]  <= '0;
         alpha_ff        <= scpb_pkg::CHAN_MAX;
      end else if (csr_wr_en) begin
         case (csr_index)
            scpb_pkg::REG_BLEND_MODE:   blend_mode_ff   <= csr_wr_data[1:0];
            scpb_pkg::REG_PIXEL_FORMAT: pixel_format_ff <= csr_wr_data[1:0];
            scpb_pkg::REG_COLOR_RED:    color_ff[scpb_pkg::CH_RED]   <= csr_wr_data;
            scpb_pkg::REG_COLOR_GREEN:  color_ff[scpb_pkg::CH_GREEN] <= csr_wr_data;
            scpb_pkg::REG_COLOR_BLUE:   color_ff[scpb_pkg::CH_BLUE]  <= csr_wr_data;
            scpb_pkg::REG_ALPHA_LEVEL:  alpha_ff        <= csr_wr_data;
            default: ;  // indexes past the list are ignored
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // a stage loads when empty or when its content moves on this edge
   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: unpack channels ----------------
   scpb_pkg::chan_type d1_in [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type d1_ff [scpb_pkg::NUM_CHAN];

   always_comb begin
      case (pixel_format_ff)
         scpb_pkg::FMT_RGB555: begin
            d1_in[scpb_pkg::CH_RED]   = {3'b000, req_tdata[14:10]};
            d1_in[scpb_pkg::CH_GREEN] = {3'b000, req_tdata[9:5]};
            d1_in[scpb_pkg::CH_BLUE]  = {3'b000, req_tdata[4:0]};
         end
         scpb_pkg::FMT_RGB565: begin
            d1_in[scpb_pkg::CH_RED]   = {3'b000, req_tdata[15:11]};
            d1_in[scpb_pkg::CH_GREEN] = {2'b00, req_tdata[10:5]};
            d1_in[scpb_pkg::CH_BLUE]  = {3'b000, req_tdata[4:0]};
         end
         default: begin
            d1_in[scpb_pkg::CH_RED]   = req_tdata[23:16];
            d1_in[scpb_pkg::CH_GREEN] = req_tdata[15:8];
            d1_in[scpb_pkg::CH_BLUE]  = req_tdata[7:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff <= d1_in;
      end
   end

   // ---------------- stage 2: products ----------------
   // pa: color * alpha (premultiply)
   // pb: dst * color for modulate, dst * (255 - alpha) otherwise
   scpb_pkg::chan_type d2_ff  [scpb_pkg::NUM_CHAN];
   scpb_pkg::prod_type pa2_in [scpb_pkg::NUM_CHAN];
   scpb_pkg::prod_type pb2_in [scpb_pkg::NUM_CHAN];
   scpb_pkg::prod_type pa2_ff [scpb_pkg::NUM_CHAN];
   scpb_pkg::prod_type pb2_ff [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type inv_alpha;

   assign inv_alpha = scpb_pkg::CHAN_MAX - alpha_ff;

   always_comb begin
      for (int i = 0; i < scpb_pkg::NUM_CHAN; i++) begin
         pa2_in[i] = scpb_pkg::prod_type'(color_ff[i]) * scpb_pkg::prod_type'(alpha_ff);
         pb2_in[i] = scpb_pkg::prod_type'(d1_ff[i]) *
                     scpb_pkg::prod_type'((blend_mode_ff == scpb_pkg::MODE_MODULATE) ?
                                          color_ff[i] : inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         d2_ff  <= d1_ff;
         pa2_ff <= pa2_in;
         pb2_ff <= pb2_in;
      end
   end

   // ---------------- stage 3: divide by 255 ----------------
   scpb_pkg::chan_type d3_ff  [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type qa3_in [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type qb3_in [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type qa3_ff [scpb_pkg::NUM_CHAN];
   scpb_pkg::chan_type qb3_ff [scpb_pkg::NUM_CHAN];

   always_comb begin
      for (int i = 0; i < scpb_pkg::NUM_CHAN; i++) begin
         qa3_in[i] = scpb_pkg::div255(pa2_ff[i]);
         qb3_in[i] = scpb_pkg::div255(pb2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         d3_ff  <= d2_ff;
         qa3_ff <= qa3_in;
         qb3_ff <= qb3_in;
      end
   end

   // ---------------- stage 4: combine, saturate, repack ----------------
   // mask with zero alpha passes the destination channels, which repack
   // to the input word with the unused bits cleared
   scpb_pkg::chan_type ch4 [scpb_pkg::NUM_CHAN];
   logic               mask_pass;
   logic [31:0]        out4_in;
   logic [31:0]        out4_ff;

   assign mask_pass = (alpha_ff == '0);

   always_comb begin
      for (int i = 0; i < scpb_pkg::NUM_CHAN; i++) begin
         ch4[i] = scpb_pkg::combine(blend_mode_ff, mask_pass,
                                    scpb_pkg::chan_drop(pixel_format_ff, i),
                                    d3_ff[i], qa3_ff[i], qb3_ff[i], color_ff[i]);
      end
      case (pixel_format_ff)
         scpb_pkg::FMT_RGB555: begin
            out4_in = {17'd0, ch4[scpb_pkg::CH_RED][4:0],
                       ch4[scpb_pkg::CH_GREEN][4:0], ch4[scpb_pkg::CH_BLUE][4:0]};
         end
         scpb_pkg::FMT_RGB565: begin
            out4_in = {16'd0, ch4[scpb_pkg::CH_RED][4:0],
                       ch4[scpb_pkg::CH_GREEN][5:0], ch4[scpb_pkg::CH_BLUE][4:0]};
         end
         default: begin
            out4_in = {8'd0, ch4[scpb_pkg::CH_RED],
                       ch4[scpb_pkg::CH_GREEN], ch4[scpb_pkg::CH_BLUE]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         out4_ff <= out4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out4_ff;

`ifndef SYNTH
   // output stage comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty pipeline must always take a pixel
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !v3_ff && !v4_ff) |-> req_tready)
      else $error("empty pipeline not ready");

   // stalled output keeps stage 3 occupied: nothing dropped behind it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && v3_ff && !rsp_tready) |=> (v3_ff && v4_ff))
      else $error("pixel lost during stall");

   // rgb555 results keep the unused top bits clear
   a_555_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pixel_format_ff == scpb_pkg::FMT_RGB555) |-> (rsp_tdata[31:15] == '0))
      else $error("rgb555 result has stray high bits");
`endif

endmodule
